FILE: design/mhd_pkg.sv
// Package for the M-PSK hard-decision unit: decision modes, side-band types
// and the constant phasor table built at elaboration time.
// Depends on nothing; used by mpsk_hard_decision_unit.
package mhd_pkg;

  localparam int GRID_LOG2 = 8;
  localparam int GRID_SIZE = 1 << GRID_LOG2;
  localparam int QUARTER   = GRID_SIZE / 4;
  localparam int ROM_W     = 16;
  localparam int ROM_FRAC  = 14;
  localparam int OUT_W     = 6;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic [1:0] {
    MODE_BPSK,
    MODE_QPSK,
    MODE_SEARCH
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [1:0] sym;
  } side_t;

  typedef logic signed [ROM_W-1:0] rom_tab_t [GRID_SIZE];

  // Long division, evaluated only while the phasor table is elaborated.
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = (rem << 1) | 64'(num[b]);
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic int series_q14(input longint unsigned a, input logic odd);
    longint unsigned a2;
    longint unsigned term;
    longint unsigned n;
    longint          sum;
    logic            neg;
    a2   = (a * a) >> 30;
    term = odd ? a : (64'd1 << 30);
    n    = odd ? 64'd1 : 64'd0;
    sum  = 0;
    neg  = 1'b0;
    for (int k = 0; k < 12; k++) begin
      if (neg) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
      term = udiv64((term * a2) >> 30, (n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      neg  = !neg;
    end
    if (sum < 0) begin
      sum = 0;
    end
    return int'(($unsigned(sum) + (64'd1 << 15)) >> 16);
  endfunction

  // One component of the full circle of unit phasors in Q1.14.
  function automatic rom_tab_t build_rom(input logic want_im);
    rom_tab_t        tab;
    int              c [QUARTER];
    int              s [QUARTER];
    longint unsigned a;
    int              x;
    int              y;
    int              re;
    int              im;
    for (int r = 0; r < QUARTER; r++) begin
      a = (PI_Q30 * 64'd2 * 64'(r) + 64'(GRID_SIZE / 2)) >> GRID_LOG2;
      c[r] = series_q14(a, 1'b0);
      s[r] = series_q14(a, 1'b1);
    end
    for (int idx = 0; idx < GRID_SIZE; idx++) begin
      x = c[idx % QUARTER];
      y = s[idx % QUARTER];
      unique case ((idx / QUARTER) % 4)
        0: begin
          re = x;
          im = y;
        end
        1: begin
          re = -y;
          im = x;
        end
        2: begin
          re = -x;
          im = -y;
        end
        default: begin
          re = y;
          im = -x;
        end
      endcase
      tab[idx] = want_im ? ROM_W'(im) : ROM_W'(re);
    end
    return tab;
  endfunction

  function automatic logic [GRID_LOG2-1:0] inv_gray(input logic [GRID_LOG2-1:0] g);
    logic [GRID_LOG2-1:0] k;
    k = g;
    k = k ^ (k >> 1);
    k = k ^ (k >> 2);
    k = k ^ (k >> 4);
    return k;
  endfunction

endpackage

FILE: design/mpsk_hard_decision_unit.sv
// Top level of the M-PSK hard-decision unit: stream ports, order register,
// per-point distance lanes and a registered minimum tree.
// Depends on mhd_pkg.

// One sample transfer is taken per clock while the output is not stalled,
// and every sample yields one symbol transfer. Each sample passes through
// the input register, the subtract, square and sum stages of the 2**MAX_ORDER_LOG2
// distance lanes, one register per level of the minimum tree and the output
// register. A stall on the output holds the whole pipeline. The user must write
// the order register only while no sample is in flight; the block does not
// enforce it. Order 0 acts as BPSK and an order above MAX_ORDER_LOG2 acts as
// MAX_ORDER_LOG2. In search mode, distance ties go to the lowest symbol value.
module mpsk_hard_decision_unit #(
  parameter int MAX_ORDER_LOG2 = 6,
  parameter int SAMPLE_WIDTH   = 16,
  localparam int IN_TDATA_W    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [2:0]                       cfg_wdata,   // order_log2
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [IN_TDATA_W-1:0]            in_tdata,    // sample_i, sample_q
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mhd_pkg::OUT_TDATA_W-1:0]  out_tdata    // symbol_index
);

  localparam int NL   = 1 << MAX_ORDER_LOG2;
  localparam int IW   = MAX_ORDER_LOG2;
  localparam int LW   = $clog2(MAX_ORDER_LOG2 + 1);
  localparam int SF   = SAMPLE_WIDTH - 1;
  localparam int CF   = (SF > mhd_pkg::ROM_FRAC) ? SF : mhd_pkg::ROM_FRAC;
  localparam int XS   = CF - SF;
  localparam int RS   = CF - mhd_pkg::ROM_FRAC;
  localparam int DW   = CF + 3;
  localparam int SQW  = 2 * DW - 2;
  localparam int DSW  = SQW + 1;
  localparam int NST  = MAX_ORDER_LOG2 + 5;
  localparam int GL   = mhd_pkg::GRID_LOG2;

  localparam mhd_pkg::rom_tab_t ROM_RE = mhd_pkg::build_rom(1'b0);
  localparam mhd_pkg::rom_tab_t ROM_IM = mhd_pkg::build_rom(1'b1);

  logic [2:0]                  order_r;
  logic [LW-1:0]               eff_l;
  logic                        adv;
  logic [NST-1:0]              vld_r;
  logic signed [SAMPLE_WIDTH-1:0] si_r;
  logic signed [SAMPLE_WIDTH-1:0] sq_r;
  logic signed [DW-1:0]        xi;
  logic signed [DW-1:0]        xq;
  mhd_pkg::side_t              side_nxt;
  mhd_pkg::side_t              side_r [1:NST-2];
  logic signed [SAMPLE_WIDTH:0] iq_sum;
  logic [DSW-1:0]              tree_d_r   [2*NL-1];
  logic [IW-1:0]               tree_idx_r [2*NL-1];
  logic                        tree_ok_r  [2*NL-1];
  logic [mhd_pkg::OUT_W-1:0]   out_sym_nxt;
  logic [mhd_pkg::OUT_W-1:0]   out_sym_r;

  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[NST-1];
  assign out_tdata  = mhd_pkg::OUT_TDATA_W'(out_sym_r);

  always_comb begin
    if (order_r == 3'd0) begin
      eff_l = LW'(1);
    end else if (int'(order_r) > MAX_ORDER_LOG2) begin
      eff_l = LW'(MAX_ORDER_LOG2);
    end else begin
      eff_l = LW'(order_r);
    end
  end

  assign xi     = DW'(si_r) <<< XS;
  assign xq     = DW'(sq_r) <<< XS;
  assign iq_sum = (SAMPLE_WIDTH + 1)'(si_r) + (SAMPLE_WIDTH + 1)'(sq_r);

  always_comb begin
    priority if (eff_l == LW'(1)) begin
      side_nxt.mode = mhd_pkg::MODE_BPSK;
    end else if (eff_l == LW'(2)) begin
      side_nxt.mode = mhd_pkg::MODE_QPSK;
    end else begin
      side_nxt.mode = mhd_pkg::MODE_SEARCH;
    end
    if (side_nxt.mode == mhd_pkg::MODE_BPSK) begin
      side_nxt.sym = (si_r > 0) ? 2'd0 : 2'd1;
    end else if (sq_r > si_r) begin
      side_nxt.sym = (iq_sum > 0) ? 2'd0 : 2'd2;
    end else begin
      side_nxt.sym = (iq_sum > 0) ? 2'd1 : 2'd3;
    end
  end

  always_comb begin
    unique case (side_r[NST-2].mode)
      mhd_pkg::MODE_SEARCH: out_sym_nxt = mhd_pkg::OUT_W'(tree_idx_r[0]);
      default:              out_sym_nxt = mhd_pkg::OUT_W'(side_r[NST-2].sym);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 3'd2;
      vld_r   <= '0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
      if (adv) begin
        vld_r <= {vld_r[NST-2:0], in_tvalid};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      si_r      <= in_tdata[SAMPLE_WIDTH-1:0];
      sq_r      <= in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      side_r[1] <= side_nxt;
      for (int s = 2; s <= NST - 2; s++) begin
        side_r[s] <= side_r[s-1];
      end
      out_sym_r <= out_sym_nxt;
    end
  end

  for (genvar g = 0; g < NL; g++) begin : g_lane
    localparam logic [GL-1:0] LANE_K = mhd_pkg::inv_gray(GL'(g));
    logic [GL-1:0]          pos;
    logic signed [DW-1:0]   dx_nxt;
    logic signed [DW-1:0]   dy_nxt;
    logic signed [DW-1:0]   dx_r;
    logic signed [DW-1:0]   dy_r;
    logic signed [2*DW-1:0] px;
    logic signed [2*DW-1:0] py;
    logic [SQW-1:0]         sqx_r;
    logic [SQW-1:0]         sqy_r;
    logic                   lane_ok;

    assign pos     = LANE_K << (GL - int'(eff_l));
    assign dx_nxt  = xi - (DW'(ROM_RE[pos]) <<< RS);
    assign dy_nxt  = xq - (DW'(ROM_IM[pos]) <<< RS);
    assign px      = dx_r * dx_r;
    assign py      = dy_r * dy_r;
    assign lane_ok = (((IW + 1)'(g)) >> eff_l) == '0;

    always_ff @(posedge clk) begin
      if (adv) begin
        dx_r  <= dx_nxt;
        dy_r  <= dy_nxt;
        sqx_r <= px[SQW-1:0];
        sqy_r <= py[SQW-1:0];
        tree_d_r[NL-1+g]   <= DSW'(sqx_r) + DSW'(sqy_r);
        tree_idx_r[NL-1+g] <= IW'(g);
        tree_ok_r[NL-1+g]  <= lane_ok;
      end
    end
  end

  for (genvar n = 0; n < NL - 1; n++) begin : g_node
    logic take_right;

    assign take_right = tree_ok_r[2*n+2] &&
                        (!tree_ok_r[2*n+1] || (tree_d_r[2*n+2] < tree_d_r[2*n+1]));

    always_ff @(posedge clk) begin
      if (adv) begin
        tree_d_r[n]   <= take_right ? tree_d_r[2*n+2]   : tree_d_r[2*n+1];
        tree_idx_r[n] <= take_right ? tree_idx_r[2*n+2] : tree_idx_r[2*n+1];
        tree_ok_r[n]  <= tree_ok_r[2*n+1] || tree_ok_r[2*n+2];
      end
    end
  end

endmodule

FILE: tb/mpsk_hard_decision_unit_tb.sv
// Self-checking testbench for mpsk_hard_decision_unit: random-rate sample stream in,
// symbol stream out, each symbol checked against an in-bench nearest-point predictor.
// Depends on mhd_pkg and mpsk_hard_decision_unit.
module mpsk_hard_decision_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                PHASOR_COUNT = 256;
  localparam int                SEGMENT      = PHASOR_COUNT / 4;
  localparam longint unsigned   PI_Q30_VAL   = 64'd3373259426;
  localparam int                CYCLE_LIMIT  = 400000;
  localparam int                LONG_HOLD    = 300;
  localparam int                PHASE_ITEMS  = 100;
  localparam int                PHASES       = 12;

  typedef struct {
    logic signed [15:0] i_val;
    logic signed [15:0] q_val;
  } sample_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [2:0]                      cfg_wdata  = '0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [31:0]                     in_tdata   = '0;    // sample_i, sample_q
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [mhd_pkg::OUT_TDATA_W-1:0] out_tdata;          // symbol_index

  int          phasor_re [PHASOR_COUNT];
  int          phasor_im [PHASOR_COUNT];
  sample_t     samples_to_send [$];
  logic [5:0]  symbols_due [$];
  logic [2:0]  active_order    = 3'd2;
  bit          idling          = 1'b1;
  int          hold_requests   = 0;
  int          holds_served    = 0;
  int          send_pause      = 0;
  int          recv_pause      = 0;
  int          cycles          = 0;
  int          errors          = 0;
  int          symbols_checked = 0;
  int          samples_sent    = 0;

  mpsk_hard_decision_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  function automatic int taylor_q14(input longint unsigned a, input bit odd);
    longint unsigned a_sq;
    longint unsigned term;
    longint unsigned n;
    longint          acc;
    bit              neg;
    a_sq = (a * a) >> 30;
    term = odd ? a : (64'd1 << 30);
    n    = odd ? 64'd1 : 64'd0;
    acc  = 0;
    neg  = 1'b0;
    for (int t = 0; t < 12; t++) begin
      acc  = neg ? acc - longint'(term) : acc + longint'(term);
      term = ((term * a_sq) >> 30) / ((n + 64'd1) * (n + 64'd2));
      n    = n + 64'd2;
      neg  = !neg;
    end
    if (acc < 0) begin
      acc = 0;
    end
    return int'(($unsigned(acc) + (64'd1 << 15)) >> 16);
  endfunction

  task automatic fill_circle();
    int              cos_q [SEGMENT];
    int              sin_q [SEGMENT];
    longint unsigned angle;
    int              x;
    int              y;
    for (int r = 0; r < SEGMENT; r++) begin
      angle    = (PI_Q30_VAL * 64'd2 * 64'(r) + 64'd128) >> 8;
      cos_q[r] = taylor_q14(angle, 1'b0);
      sin_q[r] = taylor_q14(angle, 1'b1);
    end
    for (int p = 0; p < PHASOR_COUNT; p++) begin
      x = cos_q[p % SEGMENT];
      y = sin_q[p % SEGMENT];
      case (p / SEGMENT)
        0: begin
          phasor_re[p] = x;
          phasor_im[p] = y;
        end
        1: begin
          phasor_re[p] = -y;
          phasor_im[p] = x;
        end
        2: begin
          phasor_re[p] = -x;
          phasor_im[p] = -y;
        end
        default: begin
          phasor_re[p] = y;
          phasor_im[p] = -x;
        end
      endcase
    end
  endtask

  function automatic int order_in_use(input logic [2:0] ord);
    int lvl;
    lvl = ord;
    if (lvl < 1) begin
      lvl = 1;
    end
    if (lvl > 6) begin
      lvl = 6;
    end
    return lvl;
  endfunction

  // Phasor slot of the constellation point whose Gray-coded label is g.
  function automatic int point_slot(input int g, input int lvl);
    logic [7:0] k;
    k = 8'(g);
    k = k ^ (k >> 1);
    k = k ^ (k >> 2);
    k = k ^ (k >> 4);
    return (int'(k) << (8 - lvl)) & (PHASOR_COUNT - 1);
  endfunction

  function automatic logic [5:0] decide_symbol(input logic signed [15:0] si,
                                                input logic signed [15:0] sq,
                                                input logic [2:0] ord);
    int     lvl;
    int     xi;
    int     xq;
    int     pos;
    int     best;
    longint dx;
    longint dy;
    longint dist_sq;
    longint best_dist;
    lvl       = order_in_use(ord);
    xi        = si;
    xq        = sq;
    best      = 0;
    best_dist = 0;
    if (lvl == 1) begin
      return (xi > 0) ? 6'd0 : 6'd1;
    end
    if (lvl == 2) begin
      if (xq > xi) begin
        return (xi > -xq) ? 6'd0 : 6'd2;
      end
      return (xi > -xq) ? 6'd1 : 6'd3;
    end
    for (int g = 0; g < (1 << lvl); g++) begin
      pos     = point_slot(g, lvl);
      dx      = longint'(xi) - 2 * longint'(phasor_re[pos]);
      dy      = longint'(xq) - 2 * longint'(phasor_im[pos]);
      dist_sq = dx * dx + dy * dy;
      if (g == 0 || dist_sq < best_dist) begin
        best_dist = dist_sq;
        best      = g;
      end
    end
    return 6'(best);
  endfunction

  function automatic logic signed [15:0] clip16(input int v);
    if (v > 32767) begin
      return 16'sd32767;
    end
    if (v < -32768) begin
      return -16'sd32768;
    end
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] edge_value();
    case ($urandom_range(0, 6))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      5: return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic sample_t make_sample();
    sample_t s;
    int      lvl;
    int      p1;
    int      p2;
    int      k;
    lvl = order_in_use(active_order);
    case ($urandom_range(0, 7))
      0: begin
        s.i_val = edge_value();
        s.q_val = edge_value();
      end
      1: begin
        s.i_val = 16'($urandom);
        s.q_val = $urandom_range(0, 1) ? s.i_val : -s.i_val;
      end
      2: begin
        p1      = $urandom_range(0, PHASOR_COUNT - 1);
        s.i_val = clip16(2 * phasor_re[p1] + int'($urandom_range(0, 128)) - 64);
        s.q_val = clip16(2 * phasor_im[p1] + int'($urandom_range(0, 128)) - 64);
      end
      3: begin
        // Midway between two neighboring points: both are equally close.
        k       = $urandom_range(0, (1 << lvl) - 1);
        p1      = (k << (8 - lvl)) & (PHASOR_COUNT - 1);
        p2      = ((k + 1) << (8 - lvl)) & (PHASOR_COUNT - 1);
        s.i_val = clip16(phasor_re[p1] + phasor_re[p2]);
        s.q_val = clip16(phasor_im[p1] + phasor_im[p2]);
      end
      4: begin
        s.i_val = 16'(int'($urandom_range(0, 64)) - 32);
        s.q_val = 16'(int'($urandom_range(0, 64)) - 32);
      end
      default: begin
        s.i_val = 16'($urandom);
        s.q_val = 16'($urandom);
      end
    endcase
    return s;
  endfunction

  function automatic int pick_pause();
    int r;
    if (!idling) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d symbols outstanding",
               cycles, symbols_due.size());
      $display("mpsk_hard_decision_unit: mismatch");
      $finish;
    end
  end

  // Sample driver: predicts the symbol at each accepted transfer.
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        symbols_due.push_back(decide_symbol($signed(in_tdata[15:0]),
                                            $signed(in_tdata[31:16]), active_order));
        samples_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_pause > 0) begin
          send_pause--;
          in_tvalid <= 1'b0;
        end else if (samples_to_send.size() > 0) begin
          s          = samples_to_send.pop_front();
          in_tdata   <= {s.q_val, s.i_val};
          in_tvalid  <= 1'b1;
          send_pause = pick_pause();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Symbol monitor with its own back-pressure.
  always @(posedge clk) begin
    logic [5:0] want;
    int         n;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (symbols_due.size() == 0) begin
          $error("unexpected symbol transfer: symbol_index %0d", out_tdata[5:0]);
          errors++;
        end else begin
          want = symbols_due.pop_front();
          symbols_checked++;
          if (out_tdata[5:0] !== want) begin
            $error("symbol_index: expected %0d, actual %0d", want, out_tdata[5:0]);
            errors++;
          end
        end
      end
      if (hold_requests > holds_served) begin
        holds_served++;
        recv_pause = LONG_HOLD;
      end
      if (recv_pause > 0) begin
        recv_pause--;
        out_tready <= 1'b0;
      end else begin
        n = pick_pause();
        if (n > 0) begin
          recv_pause = n - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  task automatic wait_until_idle();
    while (samples_to_send.size() != 0 || in_tvalid || symbols_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_order(input logic [2:0] ord);
    wait_until_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ord;
    @(posedge clk);
    cfg_we       <= 1'b0;
    active_order = ord;
  endtask

  task automatic queue_sample(input int i_val, input int q_val);
    sample_t s;
    s.i_val = 16'(i_val);
    s.q_val = 16'(q_val);
    samples_to_send.push_back(s);
  endtask

  initial begin
    logic [2:0] phase_orders [PHASES];
    phase_orders = '{3'd1, 3'd0, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd3, 3'd5, 3'd1, 3'd2, 3'd6};
    fill_circle();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corners at the reset order, QPSK: extremes, both diagonals, axes.
    queue_sample(0, 0);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(1, 1);
    queue_sample(1, -1);
    queue_sample(-1, 1);
    queue_sample(-1, -1);
    queue_sample(0, 1);
    queue_sample(1, 0);
    queue_sample(0, -1);
    queue_sample(-1, 0);
    queue_sample(100, 100);
    queue_sample(100, -100);
    queue_sample(32767, 0);
    queue_sample(0, 32767);
    queue_sample(-32768, 0);
    queue_sample(0, -32768);
    queue_sample(5, -7);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_order(phase_orders[ph]);
      idling = (ph != 4 && ph != 9);
      // Samples with in-phase value zero and one probe the BPSK boundary.
      queue_sample(0, 0);
      queue_sample(1, -32768);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        samples_to_send.push_back(make_sample());
      end
      if (ph == 5) begin
        hold_requests++;
      end
    end

    wait_until_idle();
    repeat (32) @(posedge clk);
    if (symbols_due.size() != 0) begin
      $error("%0d symbols never arrived", symbols_due.size());
      errors++;
    end
    $display("sent %0d samples and checked %0d symbols over all eight order settings,",
             samples_sent, symbols_checked);
    $display("with random gaps, one long output hold-off and %0d errors", errors);
    if (errors == 0) begin
      $display("mpsk_hard_decision_unit: match");
    end else begin
      $display("mpsk_hard_decision_unit: mismatch");
    end
    $finish;
  end

endmodule
